### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define LPG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/lpg_pkg.sv
package lpg_pkg;

    // fixed field widths
    localparam int SYM_W = 5;
    localparam int POS_W = 5;
    localparam int LEN_W = 5;

    // most results one item may return
    localparam int RESULT_LIMIT = 26;

    // default store depth
    localparam int DEF_MAX_SYMBOLS = 26;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request codes
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // input transaction
    typedef struct packed {
        logic             req_type;
        logic [LEN_W-1:0] length;
    } t_req;

    // output transaction
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] position;
        logic             last_symbol;
        logic             wrapped;
    } t_rsp;

    // classified command handed from front to back
    typedef struct packed {
        logic             advance;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

### hw/rtl/lpg_front.sv
module lpg_front #(
    parameter int MAX_SYMBOLS = lpg_pkg::DEF_MAX_SYMBOLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lpg_pkg::t_req i_data,
    output logic          o_stall,
    output logic          o_push,
    output lpg_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import lpg_pkg::*;

    localparam int LEN_CAP = (MAX_SYMBOLS < RESULT_LIMIT) ? MAX_SYMBOLS : RESULT_LIMIT;

    logic r_cvalid;
    logic n_cvalid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    // hand the held command to the queue when it has room
    assign o_push  = r_cvalid && !i_full;
    assign o_stall = r_cvalid && i_full;
    assign o_cmd   = r_cmd;
    assign take    = i_valid && !o_stall;

    // classify the request and clamp the length to the supported range
    always_comb begin
        n_cvalid = r_cvalid;
        n_cmd    = r_cmd;
        if (o_push) begin
            n_cvalid = 1'b0;
        end
        if (take) begin
            n_cvalid    = 1'b1;
            n_cmd.advance = (i_data.req_type == REQ_ADVANCE);
            if (i_data.length == '0) begin
                n_cmd.len = LEN_W'(1);
            end else if (i_data.length > LEN_W'(LEN_CAP)) begin
                n_cmd.len = LEN_W'(LEN_CAP);
            end else begin
                n_cmd.len = i_data.length;
            end
        end
    end

    // command holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= 1'b0;
        end else begin
            r_cvalid <= n_cvalid;
        end
        r_cmd <= n_cmd;
    end

endmodule

### hw/rtl/lpg_queue.sv
module lpg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpg_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output lpg_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import lpg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### hw/rtl/lpg_back.sv
module lpg_back #(
    parameter int MAX_SYMBOLS = lpg_pkg::DEF_MAX_SYMBOLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lpg_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_valid,
    output lpg_pkg::t_rsp o_data,
    input  logic          i_stall
);
    import lpg_pkg::*;

`include "assert_macros.svh"

    localparam int LEN_CAP = (MAX_SYMBOLS < RESULT_LIMIT) ? MAX_SYMBOLS : RESULT_LIMIT;
    localparam int AW      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PSCAN  = 10'b00_0000_0010,
        S_SSCAN  = 10'b00_0000_0100,
        S_SWAP1  = 10'b00_0000_1000,
        S_SWAP2  = 10'b00_0001_0000,
        S_RSTART = 10'b00_0010_0000,
        S_RWLO   = 10'b00_0100_0000,
        S_RWHI   = 10'b00_1000_0000,
        S_EREAD  = 10'b01_0000_0000,
        S_ELOAD  = 10'b10_0000_0000
    } t_state;

    // order store with identity reset through per-entry valid bits
    logic [SYM_W-1:0]       r_mem [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] r_vld;
    logic [SYM_W-1:0]       r_rd_a;
    logic [SYM_W-1:0]       r_rd_b;

    t_state           r_state,  n_state;
    logic [LEN_W-1:0] r_len,    n_len;
    logic             r_wrap,   n_wrap;
    logic [AW-1:0]    r_ptr,    n_ptr;
    logic [AW-1:0]    r_cidx,   n_cidx;
    logic             r_chk,    n_chk;
    logic [AW-1:0]    r_pidx,   n_pidx;
    logic [SYM_W-1:0] r_pval,   n_pval;
    logic [AW-1:0]    r_sidx,   n_sidx;
    logic [SYM_W-1:0] r_sval,   n_sval;
    logic [AW-1:0]    r_lo,     n_lo;
    logic [AW-1:0]    r_hi,     n_hi;
    logic [AW-1:0]    r_epos,   n_epos;
    logic             r_ovalid, n_ovalid;
    t_rsp             r_out,    n_out;

    logic [AW-1:0]    ra;
    logic [AW-1:0]    rb;
    logic             rd_en;
    logic             we;
    logic [AW-1:0]    wa;
    logic [SYM_W-1:0] wd;
    logic             vld_clr;
    logic             load;
    logic [AW-1:0]    last_idx;

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // sequencer: pivot scan, successor search, swap, suffix reversal, emit
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_wrap   = r_wrap;
        n_ptr    = r_ptr;
        n_cidx   = r_cidx;
        n_chk    = r_chk;
        n_pidx   = r_pidx;
        n_pval   = r_pval;
        n_sidx   = r_sidx;
        n_sval   = r_sval;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_epos   = r_epos;
        n_out    = r_out;
        ra       = '0;
        rb       = '0;
        rd_en    = 1'b0;
        we       = 1'b0;
        wa       = '0;
        wd       = '0;
        vld_clr  = 1'b0;
        load     = 1'b0;
        last_idx = AW'(r_len - LEN_W'(1));

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_epos = '0;
                    if (!i_q_cmd.advance) begin
                        vld_clr = 1'b1;
                        n_len   = i_q_cmd.len;
                        n_wrap  = 1'b0;
                        n_state = S_EREAD;
                    end else if (r_len < LEN_W'(2)) begin
                        // single symbol: no next order, report a wrap
                        n_wrap  = 1'b1;
                        n_state = S_EREAD;
                    end else begin
                        n_wrap  = 1'b0;
                        n_ptr   = last_idx;
                        n_chk   = 1'b0;
                        n_state = S_PSCAN;
                    end
                end
            end
            S_PSCAN: begin
                // read one neighbour pair a cycle, compare the pair read last cycle
                rd_en = (r_ptr != '0);
                ra    = r_ptr - AW'(1);
                rb    = r_ptr;
                if (rd_en) begin
                    n_cidx = r_ptr;
                    n_ptr  = r_ptr - AW'(1);
                    n_chk  = 1'b1;
                end
                if (r_chk) begin
                    if (r_rd_a < r_rd_b) begin
                        n_pidx  = r_cidx - AW'(1);
                        n_pval  = r_rd_a;
                        n_lo    = r_cidx;
                        n_hi    = last_idx;
                        n_ptr   = last_idx;
                        n_chk   = 1'b0;
                        n_state = S_SSCAN;
                    end else if (r_cidx == AW'(1)) begin
                        // fully descending: reverse everything back to identity
                        n_wrap  = 1'b1;
                        n_lo    = '0;
                        n_hi    = last_idx;
                        n_state = S_RSTART;
                    end
                end
            end
            S_SSCAN: begin
                // rightmost symbol larger than the pivot
                rd_en  = 1'b1;
                ra     = r_ptr;
                n_cidx = r_ptr;
                n_ptr  = r_ptr - AW'(1);
                n_chk  = 1'b1;
                if (r_chk && (r_rd_a > r_pval)) begin
                    n_sidx  = r_cidx;
                    n_sval  = r_rd_a;
                    n_state = S_SWAP1;
                end
            end
            S_SWAP1: begin
                we      = 1'b1;
                wa      = r_pidx;
                wd      = r_sval;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                we      = 1'b1;
                wa      = r_sidx;
                wd      = r_pval;
                n_state = S_RSTART;
            end
            S_RSTART: begin
                n_epos = '0;
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    ra      = r_lo;
                    rb      = r_hi;
                    n_state = S_RWLO;
                end else begin
                    n_state = S_EREAD;
                end
            end
            S_RWLO: begin
                we      = 1'b1;
                wa      = r_lo;
                wd      = r_rd_b;
                n_state = S_RWHI;
            end
            S_RWHI: begin
                // finish this pair and fetch the next one
                we   = 1'b1;
                wa   = r_hi;
                wd   = r_rd_a;
                n_lo = r_lo + AW'(1);
                n_hi = r_hi - AW'(1);
                if ((r_lo + AW'(1)) < (r_hi - AW'(1))) begin
                    rd_en   = 1'b1;
                    ra      = r_lo + AW'(1);
                    rb      = r_hi - AW'(1);
                    n_state = S_RWLO;
                end else begin
                    n_epos  = '0;
                    n_state = S_EREAD;
                end
            end
            S_EREAD: begin
                rd_en   = 1'b1;
                ra      = r_epos;
                n_state = S_ELOAD;
            end
            S_ELOAD: begin
                // one symbol a cycle into the output register while the output is not stalled
                load = !r_ovalid || !i_stall;
                if (load) begin
                    n_out.symbol      = r_rd_a;
                    n_out.position    = POS_W'(r_epos);
                    n_out.last_symbol = (r_epos == last_idx);
                    n_out.wrapped     = r_wrap;
                    if (r_epos == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_epos = r_epos + AW'(1);
                        rd_en  = 1'b1;
                        ra     = r_epos + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // store array and registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_a <= r_vld[ra] ? r_mem[ra] : SYM_W'(ra);
            r_rd_b <= r_vld[rb] ? r_mem[rb] : SYM_W'(rb);
        end
    end

    // entry valid bits, cleared on reset and on restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (vld_clr) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= LEN_W'(LEN_CAP);
            r_wrap   <= 1'b0;
            r_chk    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_wrap   <= n_wrap;
            r_chk    <= n_chk;
            r_ovalid <= n_ovalid;
        end
        r_ptr  <= n_ptr;
        r_cidx <= n_cidx;
        r_pidx <= n_pidx;
        r_pval <= n_pval;
        r_sidx <= n_sidx;
        r_sval <= n_sval;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_epos <= n_epos;
        r_out  <= n_out;
    end

    `LPG_ASSERT(a_wr_in_range, we |-> (LEN_W'(wa) < r_len), "store write beyond active length")
    `LPG_ASSERT(a_swap_order, (r_state == S_SWAP1) |-> (r_pidx < r_sidx), "successor not right of pivot")
    `LPG_ASSERT(a_succ_larger, (r_state == S_SWAP1) |-> (r_sval > r_pval), "successor not above pivot")
    `LPG_ASSERT(a_rev_span, (r_state == S_RWLO) |-> (r_lo < r_hi), "reversal pair crossed over")
    `LPG_ASSERT_NEXT(a_restart_clear, (o_pop && !i_q_cmd.advance), (r_vld == '0), "restart left entries set")

endmodule

### hw/rtl/lexicographic_permutation_generator.sv
// Lexicographic permutation generator. Holds a permutation of the symbols
// 0..length-1 (0 stands for letter A). A restart transaction loads the identity
// order for its length (0 taken as 1, anything above the cap taken as the cap,
// cap = min(MAX_SYMBOLS, 26)); an advance transaction steps to the next order
// in lexicographic order, wrapping from the descending order back to the
// identity with wrapped set on all its results. Each transaction returns one
// result per symbol, position 0 first, last_symbol on the final one. Input
// transactions go through a register and a two-entry queue, so up to three can
// be taken while the back end is busy. An advance of two or more symbols runs
// the pivot scan, then the successor search, swap and suffix reversal (or, on
// a wrap, a reversal of the whole order) before the serial output; a restart
// goes straight to the serial output. All steps use the single write port and
// registered reads of the order store, and output stalls hold the serial output.
module lexicographic_permutation_generator #(
    parameter int MAX_SYMBOLS = lpg_pkg::DEF_MAX_SYMBOLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lpg_pkg::t_req i_data,
    output logic          o_stall,
    output logic          o_valid,
    output lpg_pkg::t_rsp o_data,
    input  logic          i_stall
);
    import lpg_pkg::*;

    logic push;
    t_cmd front_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // request classification
    lpg_front #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    // command queue
    lpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // permutation sequencer and output
    lpg_back #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

### tb/lpg_order_checker.sv
module lpg_order_checker #(
    parameter int MAX_SYMBOLS = lpg_pkg::DEF_MAX_SYMBOLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  lpg_pkg::t_req i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  lpg_pkg::t_rsp i_out_data,
    output int            o_pending,
    output int            o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    // longest permutation the block will hold
    localparam int LEN_CAP = (MAX_SYMBOLS < RESULT_LIMIT) ? MAX_SYMBOLS : RESULT_LIMIT;

    // predicted order store and length
    logic [SYM_W-1:0] order_q [RESULT_LIMIT];
    int               cur_len;

    // symbols still to come out, oldest first
    t_rsp             expected_symbols_q [$];
    int               error_count = 0;

    assign o_errors = error_count;

    // identity order over the whole store
    function automatic void load_identity();
        for (int k = 0; k < RESULT_LIMIT; k++) begin
            order_q[k] = SYM_W'(k);
        end
    endfunction

    // reverse the entries lo..hi in place
    function automatic void flip_span(int lo, int hi);
        logic [SYM_W-1:0] t;
        while (lo < hi) begin
            t          = order_q[lo];
            order_q[lo] = order_q[hi];
            order_q[hi] = t;
            lo++;
            hi--;
        end
    endfunction

    // step to the next order, returns 1 when it wrapped to the identity
    function automatic logic next_order();
        int               piv;
        int               succ;
        logic [SYM_W-1:0] t;
        // a single symbol has no successor
        if (cur_len < 2) begin
            return 1'b1;
        end
        piv = cur_len - 1;
        while (piv > 0 && order_q[piv-1] >= order_q[piv]) begin
            piv--;
        end
        // fully descending: back to the identity
        if (piv == 0) begin
            flip_span(0, cur_len - 1);
            return 1'b1;
        end
        piv--;
        succ = cur_len - 1;
        while (order_q[succ] <= order_q[piv]) begin
            succ--;
        end
        t             = order_q[piv];
        order_q[piv]  = order_q[succ];
        order_q[succ] = t;
        flip_span(piv + 1, cur_len - 1);
        return 1'b0;
    endfunction

    // work out the symbols one accepted transaction will emit
    function automatic void predict_symbols(t_req req);
        logic wrap;
        int   len;
        t_rsp exp_item;
        wrap = 1'b0;
        if (req.req_type == REQ_RESTART) begin
            // zero acts as one, anything over the cap saturates
            len = int'(req.length);
            if (len < 1) begin
                len = 1;
            end
            if (len > LEN_CAP) begin
                len = LEN_CAP;
            end
            cur_len = len;
            load_identity();
        end else begin
            wrap = next_order();
        end
        for (int k = 0; k < cur_len; k++) begin
            exp_item = '{symbol: order_q[k], position: POS_W'(k),
                         last_symbol: (k == cur_len - 1), wrapped: wrap};
            expected_symbols_q.insert(expected_symbols_q.size(), exp_item);
        end
    endfunction

    // one field against its prediction
    function automatic void compare_field(string name, logic [SYM_W-1:0] exp_v,
                                          logic [SYM_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            error_count++;
        end
    endfunction

    // compare one output transaction with the oldest prediction
    function automatic void check_symbol(t_rsp got);
        t_rsp exp_rsp;
        if (expected_symbols_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual symbol %0d position %0d",
                     $time, got.symbol, got.position);
            error_count++;
        end else begin
            exp_rsp = expected_symbols_q.pop_front();
            compare_field("symbol", exp_rsp.symbol, got.symbol);
            compare_field("position", exp_rsp.position, got.position);
            compare_field("last_symbol", SYM_W'(exp_rsp.last_symbol), SYM_W'(got.last_symbol));
            compare_field("wrapped", SYM_W'(exp_rsp.wrapped), SYM_W'(got.wrapped));
        end
    endfunction

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_identity();
            cur_len = LEN_CAP;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_symbols(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_symbol(i_out_data);
            end
        end
        o_pending <= expected_symbols_q.size();
    end

endmodule

### tb/tb_lexicographic_permutation_generator.sv
module tb_lexicographic_permutation_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 450;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 600;
    localparam int PAUSE_AT       = 250;
    localparam int QUIET_FROM     = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    t_req req_data;
    logic req_stall;
    logic rsp_valid;
    t_rsp rsp_data;
    logic rsp_stall;
    int   pending;
    int   errors;
    logic quiet;
    logic long_hold;
    int   sent = 0;

    // clock generation
    always #CLK_HALF_NS clk = ~clk;

    lexicographic_permutation_generator u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .i_data  (req_data),
        .o_stall (req_stall),
        .o_valid (rsp_valid),
        .o_data  (rsp_data),
        .i_stall (rsp_stall)
    );

    lpg_order_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_stall  (req_stall),
        .i_in_data   (req_data),
        .i_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .i_out_data  (rsp_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // offer one transaction, with an optional gap beforehand
    task automatic send_req(input logic kind, input logic [LEN_W-1:0] len);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{req_type: kind, length: len};
        do @(posedge clk); while (req_stall);
        sent++;
        if (sent == HOLD_AT) begin
            long_hold <= 1'b1;
        end
        if (sent == QUIET_FROM) begin
            quiet <= 1'b1;
        end
    endtask

    // hold the sender off until every symbol has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // output stall: random bursts, one long hold-off, none at the end
    initial begin : rsp_stall_gen
        bit hold_done;
        hold_done = 1'b0;
        rsp_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end else if (!quiet) begin
                if ($urandom_range(0, 2) == 0) begin
                    rsp_stall <= 1'b1;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                    rsp_stall <= 1'b0;
                end else begin
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        int               pick;
        int               eff_len;
        int               n_adv;
        logic [LEN_W-1:0] len;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        quiet     <= 1'b0;
        long_hold <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advance straight from the reset order
        send_req(REQ_ADVANCE, 5'd31);
        // zero length acts as one, single symbol advance wraps
        send_req(REQ_RESTART, 5'd0);
        send_req(REQ_ADVANCE, 5'd0);
        send_req(REQ_RESTART, 5'd1);
        send_req(REQ_ADVANCE, 5'd17);
        // two symbols: one step then the wrap
        send_req(REQ_RESTART, 5'd2);
        send_req(REQ_ADVANCE, 5'd0);
        send_req(REQ_ADVANCE, 5'd31);
        // three symbols through all six orders and the wrap
        send_req(REQ_RESTART, 5'd3);
        repeat (6) send_req(REQ_ADVANCE, 5'($urandom_range(0, 31)));
        // over-long restarts saturate to the cap
        send_req(REQ_RESTART, 5'd31);
        send_req(REQ_ADVANCE, 5'd0);
        send_req(REQ_RESTART, 5'd27);
        send_req(REQ_ADVANCE, 5'd31);
        send_req(REQ_ADVANCE, 5'd31);
        send_req(REQ_RESTART, 5'd26);
        send_req(REQ_RESTART, 5'd16);
        send_req(REQ_ADVANCE, 5'd16);

        // random part: mostly a restart followed by a run of advances
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    len = 5'($urandom_range(2, 4));
                end else if (pick < 75) begin
                    len = 5'($urandom_range(5, 7));
                end else if (pick < 88) begin
                    len = 5'($urandom_range(8, 26));
                end else if (pick < 94) begin
                    len = 5'($urandom_range(0, 1));
                end else begin
                    len = 5'($urandom_range(27, 31));
                end
                eff_len = (len == 0) ? 1 : (len > RESULT_LIMIT) ? RESULT_LIMIT : int'(len);
                // short orders run through the wrap, long ones take a few steps
                if (eff_len <= 4) begin
                    n_adv = ((eff_len == 1) ? 1 : (eff_len == 2) ? 2 : (eff_len == 3) ? 6 : 24)
                            + $urandom_range(0, 2);
                end else if (eff_len < 20) begin
                    n_adv = $urandom_range(1, 10);
                end else begin
                    n_adv = $urandom_range(1, 4);
                end
                send_req(REQ_RESTART, len);
                if (sent == PAUSE_AT) begin
                    wait_drained();
                end
                repeat (n_adv) begin
                    send_req(REQ_ADVANCE, 5'($urandom_range(0, 31)));
                    if (sent == PAUSE_AT) begin
                        wait_drained();
                    end
                end
            end else begin
                // noise: a lone transaction of any kind
                send_req(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
                if (sent == PAUSE_AT) begin
                    wait_drained();
                end
            end
        end
        req_valid <= 1'b0;

        // let the last symbols come out, then settle
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_front.sv
hw/rtl/lpg_queue.sv
hw/rtl/lpg_back.sv
hw/rtl/lexicographic_permutation_generator.sv
tb/lpg_order_checker.sv
tb/tb_lexicographic_permutation_generator.sv
